/* sv/cekc_pkg.sv */
// Shared types and constants for the clamped-edge kernel convolution block.
// Used by cekc_mac and clamped_edge_kernel_convolution; depends on nothing.
`default_nettype none

package cekc_pkg;

   // Fixed field widths.
   localparam int OP_W    = 2;
   localparam int COORD_W = 10;
   localparam int PIX_W   = 16;
   localparam int KIDX_W  = 4;
   localparam int COEF_W  = 16;
   localparam int RES_W   = 32;
   localparam int DIM_W   = 11;
   localparam int KSZ_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Signed width for tap coordinates before clamping (covers sizes up to 4096).
   localparam int CW = 15;

   // Product of unsigned pixel and signed coefficient, and the running sum.
   localparam int PROD_W = PIX_W + COEF_W + 1;
   localparam int ACC_W  = 42;
   localparam int FRAC_BITS = 12;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_COEFF = 2'd0,
      OP_WRITE_PIXEL = 2'd1,
      OP_COMPUTE     = 2'd2,
      OP_NONE        = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_SIZE  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      opcode_type                 opcode;
      logic [COORD_W-1:0]         x_coord;
      logic [COORD_W-1:0]         y_coord;
      logic [PIX_W-1:0]           pixel_value;
      logic [KIDX_W-1:0]          coeff_row;
      logic [KIDX_W-1:0]          coeff_col;
      logic signed [COEF_W-1:0]   coeff_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [RES_W-1:0] filtered_value;
      logic                    saturated;
   } rsp_payload_type;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;      // start of a new sum
      logic tap_valid;  // pixel and coefficient inputs hold a tap
      logic round_en;   // take magnitude and round the final sum
      logic emit;       // saturate and load the result register
   } mac_ctl_type;

endpackage

`default_nettype wire

/* sv/cekc_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation of the final sum.
// Depends on cekc_pkg.
`default_nettype none

module cekc_mac
   import cekc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mac_ctl_type               ctl,
   input  wire logic [PIX_W-1:0]          pixel,
   input  wire logic signed [COEF_W-1:0]  coeff,
   output rsp_payload_type                result
);

   localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W-1:0] POS_MAX  = ACC_W'(32'h7FFF_FFFF);
   localparam logic [ACC_W-1:0] NEG_MAX  = ACC_W'(32'h8000_0000);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         rnd_ff;
   logic                     neg_ff;
   rsp_payload_type          result_ff;

   logic [ACC_W-1:0]         mag;
   logic signed [ACC_W-1:0]  prod_ext;
   logic                     sat;
   logic [RES_W-1:0]         mag_out;

   assign prod_ext = ACC_W'(prod_ff);
   assign mag      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   always_comb begin
      sat     = 1'b0;
      mag_out = rnd_ff[RES_W-1:0];
      if (!neg_ff && rnd_ff > POS_MAX) begin
         sat     = 1'b1;
         mag_out = POS_MAX[RES_W-1:0];
      end else if (neg_ff && rnd_ff > NEG_MAX) begin
         sat     = 1'b1;
         mag_out = NEG_MAX[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.tap_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= signed'({1'b0, pixel}) * coeff;
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + prod_ext;
      end
      if (ctl.round_en) begin
         neg_ff <= acc_ff[ACC_W-1];
         rnd_ff <= (mag + HALF_LSB) >> FRAC_BITS;
      end
      if (ctl.emit) begin
         result_ff.filtered_value <= neg_ff ? signed'(-mag_out) : signed'(mag_out);
         result_ff.saturated      <= sat;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* sv/clamped_edge_kernel_convolution.sv */
// Top level of the clamped-edge kernel convolution block: sequencer, pixel and
// kernel memories, tap address generation. Depends on cekc_pkg and cekc_mac.
`default_nettype none

// Usage:
// A command beat is taken when start is high and busy is low. Opcode 0 writes
// one kernel coefficient, opcode 1 writes one pixel; both finish in the accept
// cycle and leave busy low. Opcode 3 is dropped. Opcode 2 computes one filtered
// pixel from the c by c taps, where c is the effective kernel size: busy rises,
// and in the first cycle with busy low again rsp_valid is high for exactly one
// cycle with the result beat on rsp_data. The single multiply-accumulate unit
// takes one tap per cycle; after the tap walk come the memory read, the product
// register, rounding and saturation.
// The receiver cannot stall: a result beat is shown once and not held, and a
// new command may be accepted in the same cycle that the strobe is shown.
// Register writes on the csr_ port take effect at once and are to be made
// only while busy is low. Synchronous reset returns the sequencer to idle and
// loads width 1024, height 1024 and kernel size 3; the memories are not
// cleared and hold whatever was written last.
module clamped_edge_kernel_convolution
   import cekc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 15
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DIM_W-1:0]      csr_wdata
);

   localparam int XW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PA_W = XW + YW;
   localparam int KA_W = 2 * KIDX_W;
   localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);
   localparam logic [5:0]    MAXK_C = 6'(MAX_KERNEL);

   // Configuration registers.
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [KSZ_W-1:0] ksize_ff;

   // Sequencer.
   state_type         state_ff, state_in;
   logic [KIDX_W-1:0] ti_ff, tj_ff;
   logic              drain_ff;
   logic              rd_vld_ff;
   logic              rsp_valid_ff;

   // Per-item operands captured at accept.
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [KSZ_W-1:0]   kc_ff;
   logic [KSZ_W-1:0]   half_ff;
   logic [CW-1:0]      wlast_ff, hlast_ff;

   // Memories.
   logic [PIX_W-1:0]  pix_mem  [2**PA_W];
   logic [COEF_W-1:0] coef_mem [2**KA_W];
   logic [PIX_W-1:0]  pix_rd_ff;
   logic [COEF_W-1:0] coef_rd_ff;

   logic              accept;
   opcode_type        op;
   logic              do_compute;
   logic [CW-1:0]     w_eff, h_eff;
   logic [KSZ_W-1:0]  k_eff;
   logic [CW-1:0]     wx, wy;
   logic              pix_we, coef_we;
   logic [PA_W-1:0]   pix_waddr, pix_raddr;
   logic [KA_W-1:0]   coef_waddr, coef_raddr;
   logic signed [CW-1:0] px_s, py_s;
   logic [CW-1:0]     px, py;
   logic              last_col, last_tap;
   mac_ctl_type       mac_ctl;

   assign accept     = start && !busy;
   assign op         = req_data.opcode;
   assign do_compute = accept && (op == OP_COMPUTE);

   // Effective image size and kernel size.
   always_comb begin
      w_eff = CW'(width_ff);
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (CW'(width_ff) > MAXW_C) begin
         w_eff = MAXW_C;
      end
      h_eff = CW'(height_ff);
      if (height_ff == '0) begin
         h_eff = CW'(1);
      end else if (CW'(height_ff) > MAXH_C) begin
         h_eff = MAXH_C;
      end
      k_eff = ksize_ff;
      if (6'(ksize_ff) > MAXK_C) begin
         k_eff = KSZ_W'(MAXK_C);
      end
   end

   // Command writes into the stores.
   assign wx        = CW'(req_data.x_coord);
   assign wy        = CW'(req_data.y_coord);
   assign pix_we    = accept && (op == OP_WRITE_PIXEL) && (wx < MAXW_C) && (wy < MAXH_C);
   assign pix_waddr = {wy[YW-1:0], wx[XW-1:0]};
   assign coef_we   = accept && (op == OP_WRITE_COEFF)
                      && (6'(req_data.coeff_row) < MAXK_C)
                      && (6'(req_data.coeff_col) < MAXK_C);
   assign coef_waddr = {req_data.coeff_row, req_data.coeff_col};

   // Tap position, clamped into the image.
   always_comb begin
      px_s = signed'(CW'(x_ff)) - signed'(CW'(half_ff)) + signed'(CW'(ti_ff));
      py_s = signed'(CW'(y_ff)) - signed'(CW'(half_ff)) + signed'(CW'(tj_ff));
      if (px_s < 0) begin
         px = '0;
      end else if (px_s > signed'(wlast_ff)) begin
         px = wlast_ff;
      end else begin
         px = CW'(px_s);
      end
      if (py_s < 0) begin
         py = '0;
      end else if (py_s > signed'(hlast_ff)) begin
         py = hlast_ff;
      end else begin
         py = CW'(py_s);
      end
   end

   assign pix_raddr  = {py[YW-1:0], px[XW-1:0]};
   assign coef_raddr = {ti_ff, tj_ff};
   assign last_col   = (tj_ff == kc_ff - KSZ_W'(1));
   assign last_tap   = last_col && (ti_ff == kc_ff - KSZ_W'(1));

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[pix_waddr] <= req_data.pixel_value;
      end
      pix_rd_ff <= pix_mem[pix_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_data.coeff_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1024);
         height_ff <= DIM_W'(1024);
         ksize_ff  <= KSZ_W'(3);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_KERNEL_SIZE:  ksize_ff  <= csr_wdata[KSZ_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_compute) begin
               state_in = (k_eff == '0) ? ST_DRAIN : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_EMIT;
         ST_EMIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ti_ff        <= '0;
         tj_ff        <= '0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= (state_ff == ST_ISSUE);
         rsp_valid_ff <= (state_ff == ST_EMIT);
         drain_ff     <= (state_ff == ST_DRAIN) && !drain_ff;
         if (do_compute) begin
            ti_ff <= '0;
            tj_ff <= '0;
         end else if (state_ff == ST_ISSUE) begin
            if (last_col) begin
               tj_ff <= '0;
               ti_ff <= ti_ff + KIDX_W'(1);
            end else begin
               tj_ff <= tj_ff + KIDX_W'(1);
            end
         end
      end
   end

   // Operands held for the whole tap walk.
   always_ff @(posedge clock) begin
      if (do_compute) begin
         x_ff     <= req_data.x_coord;
         y_ff     <= req_data.y_coord;
         kc_ff    <= k_eff;
         half_ff  <= k_eff >> 1;
         wlast_ff <= w_eff - CW'(1);
         hlast_ff <= h_eff - CW'(1);
      end
   end

   always_comb begin
      mac_ctl.clear     = do_compute;
      mac_ctl.tap_valid = rd_vld_ff;
      mac_ctl.round_en  = (state_ff == ST_ROUND);
      mac_ctl.emit      = (state_ff == ST_EMIT);
   end

   cekc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .pixel  (pix_rd_ff),
      .coeff  (signed'(coef_rd_ff)),
      .result (rsp_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_rsp_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result beat without a finished sum");

   a_busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("block became busy without a command");

   a_tap_in_kernel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (ti_ff < kc_ff) && (tj_ff < kc_ff))
      else $error("tap counter outside the kernel");

   a_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_ISSUE || state_ff == ST_DRAIN))
      else $error("tap read outside the tap walk");
`endif

endmodule

`default_nettype wire
